// ===== hdl/mic_pkg.sv =====
`timescale 1ns / 1ps
package mic_pkg;

	// Field widths
	localparam int RawW    = 20;
	localparam int CountW  = 8;
	localparam int SampW   = 16;
	localparam int SensW   = 24;
	localparam int HardW   = 32;
	localparam int CoefW   = 16;
	localparam int RowW    = 3 * CoefW;
	localparam int FieldW  = 32;

	// Datapath widths
	localparam int ProdW   = RawW + SensW + 1;          // signed raw x unsigned sensitivity
	localparam int MagW    = ProdW - 1;                 // magnitude of that product
	localparam int QuoW    = 36;                        // quotient of (mag + n*128) >> 8 by n
	localparam int DivBits = 4;                         // quotient bits per divider stage
	localparam int DivStg  = QuoW / DivBits;
	localparam int MW      = QuoW + 2;                  // signed quotient minus offset
	localparam int MulW    = MW + CoefW;
	localparam int SumW    = MulW + 2;
	localparam int FracW   = 13;

	// Pipeline depths
	localparam int AxisLat = 3 + DivStg + 1;
	localparam int Lat     = AxisLat + 3;

	localparam int MaxSumCount = 255;

	// Register map, byte address 8*i
	localparam int CfgAddrW = 6;
	localparam int CfgDataW = 64;
	typedef enum logic [2:0] {
		REG_SENS   = 3'd0,
		REG_HARD_X = 3'd1,
		REG_HARD_Y = 3'd2,
		REG_HARD_Z = 3'd3,
		REG_ROW_X  = 3'd4,
		REG_ROW_Y  = 3'd5,
		REG_ROW_Z  = 3'd6
	} reg_idx_t;

	localparam logic [SensW-1:0] SensRst = 24'd15392;
	localparam logic [RowW-1:0]  RowXRst = 48'h0000_0000_2000;
	localparam logic [RowW-1:0]  RowYRst = 48'h0000_2000_0000;
	localparam logic [RowW-1:0]  RowZRst = 48'h2000_0000_0000;

endpackage

// ===== hdl/magnetometer_iron_calibration_core.sv =====
`timescale 1ns / 1ps
// Each result passes the per-axis stages, then product, row-sum and output registers.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// The divide by the sample count runs as a nine-stage restoring divider, four bits a stage.
// Reset clears the valid bits and loads the calibration registers with the
// default sensitivity, zero offsets and an identity matrix.
module magnetometer_iron_calibration_core import mic_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// s_tdata: raw_sum_x, raw_sum_y, raw_sum_z, sum_count, sample_number
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [87:0]         s_tdata,
	// m_tdata: field_x, field_y, field_z, sample_number_out
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [111:0]        m_tdata,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready
);

	logic [SensW-1:0] sens_q;
	logic [HardW-1:0] hard_q [0:2];
	logic [RowW-1:0]  row_q  [0:2];

	logic              en;
	logic              vld_s  [1:Lat];
	logic [SampW-1:0]  samp_s [1:Lat];

	logic signed [MW-1:0]   m_ax   [0:2];
	logic signed [MulW-1:0] prod_s14 [0:2][0:2];
	logic signed [SumW-1:0] sum_s15  [0:2];
	logic [FieldW-1:0]      fld_s16  [0:2];

	reg_idx_t widx;
	logic     wr;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[5:3]);
	assign wr     = psel & penable & pwrite;

	// Write the calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q    <= SensRst;
			hard_q[0] <= '0;
			hard_q[1] <= '0;
			hard_q[2] <= '0;
			row_q[0]  <= RowXRst;
			row_q[1]  <= RowYRst;
			row_q[2]  <= RowZRst;
		end else if (wr) begin
			case (widx)
				REG_SENS:   sens_q    <= pwdata[SensW-1:0];
				REG_HARD_X: hard_q[0] <= pwdata[HardW-1:0];
				REG_HARD_Y: hard_q[1] <= pwdata[HardW-1:0];
				REG_HARD_Z: hard_q[2] <= pwdata[HardW-1:0];
				REG_ROW_X:  row_q[0]  <= pwdata[RowW-1:0];
				REG_ROW_Y:  row_q[1]  <= pwdata[RowW-1:0];
				REG_ROW_Z:  row_q[2]  <= pwdata[RowW-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (widx)
			REG_SENS:   prdata = CfgDataW'(sens_q);
			REG_HARD_X: prdata = CfgDataW'(hard_q[0]);
			REG_HARD_Y: prdata = CfgDataW'(hard_q[1]);
			REG_HARD_Z: prdata = CfgDataW'(hard_q[2]);
			REG_ROW_X:  prdata = CfgDataW'(row_q[0]);
			REG_ROW_Y:  prdata = CfgDataW'(row_q[1]);
			REG_ROW_Z:  prdata = CfgDataW'(row_q[2]);
			default:    prdata = '0;
		endcase
	end

	// Advance the pipeline unless a result is held
	assign en       = !vld_s[Lat] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= Lat; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int i = 2; i <= Lat; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			samp_s[1] <= s_tdata[83:68];
			for (int i = 2; i <= Lat; i++) samp_s[i] <= samp_s[i-1];
		end
	end

	// Per-axis scale, divide and offset
	genvar a;
	generate
		for (a = 0; a < 3; a++) begin : g_axis
			mic_axis u_axis (
				.clk    (clk),
				.en     (en),
				.raw    (s_tdata[a*RawW +: RawW]),
				.cnt    (s_tdata[3*RawW +: CountW]),
				.sens   (sens_q),
				.hard   (hard_q[a]),
				.m      (m_ax[a])
			);
		end
	endgenerate

	// Soft-iron matrix: products, row sums, round and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s14[r][c] <= MulW'($signed(row_q[r][c*CoefW +: CoefW]) * m_ax[c]);
				end
				sum_s15[r] <= SumW'(prod_s14[r][0]) + SumW'(prod_s14[r][1])
				            + SumW'(prod_s14[r][2]);
			end
		end
	end

	generate
		for (a = 0; a < 3; a++) begin : g_out
			logic [SumW-1:0]       smag;
			logic [SumW-FracW-1:0] rnd;
			logic [FieldW-1:0]     sat;
			logic                  neg;

			always_comb begin
				neg  = sum_s15[a][SumW-1];
				smag = neg ? SumW'(-sum_s15[a]) : SumW'(sum_s15[a]);
				rnd  = (SumW-FracW)'((smag + SumW'(1 << (FracW-1))) >> FracW);
				if (neg) begin
					if (rnd > (SumW-FracW)'(64'h8000_0000)) sat = 32'h8000_0000;
					else sat = FieldW'(-rnd);
				end else begin
					if (rnd > (SumW-FracW)'(64'h7FFF_FFFF)) sat = 32'h7FFF_FFFF;
					else sat = FieldW'(rnd);
				end
			end

			always_ff @(posedge clk) begin
				if (en) fld_s16[a] <= sat;
			end
		end
	endgenerate

	assign m_tvalid = vld_s[Lat];
	assign m_tdata  = {samp_s[Lat], fld_s16[2], fld_s16[1], fld_s16[0]};

endmodule

// ===== hdl/mic_axis.sv =====
`timescale 1ns / 1ps
module mic_axis import mic_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic        [RawW-1:0]  raw,
	input  logic        [CountW-1:0] cnt,
	input  logic        [SensW-1:0] sens,
	input  logic        [HardW-1:0] hard,
	output logic signed [MW-1:0]    m
);

	logic signed [RawW-1:0]  raw_s1;
	logic [CountW-1:0]       n_s1;
	logic signed [ProdW-1:0] p_s2;
	logic [CountW-1:0]       n_s2;
	logic [QuoW-1:0]         u_s3;
	logic [CountW-1:0]       n_s3;
	logic                    neg_s3;

	logic [CountW-1:0] rem_sd [0:DivStg-1];
	logic [QuoW-1:0]   quo_sd [0:DivStg-1];
	logic [QuoW-1:0]   dvd_sd [0:DivStg-1];
	logic [CountW-1:0] n_sd   [0:DivStg-1];
	logic              neg_sd [0:DivStg-1];

	logic signed [MW-1:0] m_sm;

	logic [MagW-1:0]   mag;
	logic [MagW:0]     biased;
	logic signed [QuoW:0] qs;

	// Clamp the count to one at the low end
	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= raw;
			n_s1   <= (cnt == '0) ? CountW'(1) : cnt;
		end
	end

	// Scale by sensitivity
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= ProdW'(raw_s1 * $signed({1'b0, sens}));
			n_s2 <= n_s1;
		end
	end

	// Take magnitude, add half the divisor, drop eight bits
	always_comb begin
		mag    = p_s2[ProdW-1] ? MagW'(-p_s2) : MagW'(p_s2);
		biased = {1'b0, mag} + (MagW+1)'({n_s2, 7'd0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s3   <= biased[QuoW+7:8];
			n_s3   <= n_s2;
			neg_s3 <= p_s2[ProdW-1];
		end
	end

	// Restoring divider, several quotient bits per stage
	genvar k;
	generate
		for (k = 0; k < DivStg; k++) begin : g_div
			logic [CountW-1:0] rem_in;
			logic [QuoW-1:0]   quo_in;
			logic [QuoW-1:0]   dvd_in;
			logic [CountW-1:0] n_in;
			logic              neg_in;
			logic [CountW-1:0] rem_nx;
			logic [QuoW-1:0]   quo_nx;
			logic [QuoW-1:0]   dvd_nx;
			logic [CountW:0]   r9;

			if (k == 0) begin : g_first
				assign rem_in = '0;
				assign quo_in = '0;
				assign dvd_in = u_s3;
				assign n_in   = n_s3;
				assign neg_in = neg_s3;
			end else begin : g_next
				assign rem_in = rem_sd[k-1];
				assign quo_in = quo_sd[k-1];
				assign dvd_in = dvd_sd[k-1];
				assign n_in   = n_sd[k-1];
				assign neg_in = neg_sd[k-1];
			end

			always_comb begin
				rem_nx = rem_in;
				quo_nx = quo_in;
				dvd_nx = dvd_in;
				r9     = '0;
				for (int j = 0; j < DivBits; j++) begin
					r9     = {rem_nx, dvd_nx[QuoW-1]};
					dvd_nx = {dvd_nx[QuoW-2:0], 1'b0};
					if (r9 >= {1'b0, n_in}) begin
						rem_nx = CountW'(r9 - {1'b0, n_in});
						quo_nx = {quo_nx[QuoW-2:0], 1'b1};
					end else begin
						rem_nx = r9[CountW-1:0];
						quo_nx = {quo_nx[QuoW-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[k] <= rem_nx;
					quo_sd[k] <= quo_nx;
					dvd_sd[k] <= dvd_nx;
					n_sd[k]   <= n_in;
					neg_sd[k] <= neg_in;
				end
			end
		end
	endgenerate

	// Restore sign and subtract the hard-iron offset
	always_comb begin
		qs = neg_sd[DivStg-1] ? -$signed({1'b0, quo_sd[DivStg-1]})
		                      :  $signed({1'b0, quo_sd[DivStg-1]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_sm <= MW'(qs) - MW'($signed(hard));
		end
	end

	assign m = m_sm;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import mic_pkg::*;

	// Request and result layouts as packed on the stream buses
	typedef struct {
		logic signed [RawW-1:0] raw_x;
		logic signed [RawW-1:0] raw_y;
		logic signed [RawW-1:0] raw_z;
		logic [CountW-1:0]      count;
		logic [SampW-1:0]       sample;
	} request_t;

	typedef struct {
		logic signed [FieldW-1:0] fx;
		logic signed [FieldW-1:0] fy;
		logic signed [FieldW-1:0] fz;
		logic [SampW-1:0]         sample;
	} field_t;

	// One row of the directed table: a request, and optionally a known field
	typedef struct {
		request_t req;
		bit       known;
		field_t   fld;
	} vector_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [87:0]         s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [111:0]        m_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [CfgAddrW-1:0] paddr;
	logic [CfgDataW-1:0] pwdata;
	logic [CfgDataW-1:0] prdata;
	logic                pready;

	magnetometer_iron_calibration_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Calibration copy kept alongside the block
	logic [SensW-1:0]        cal_sens;
	logic signed [HardW-1:0] cal_hard [3];
	logic [RowW-1:0]         cal_row [3];

	field_t   field_q[$];
	request_t pending_q[$];
	bit       known_q[$];
	field_t   known_fld_q[$];

	int  mismatches;
	int  idle_cycles;
	bit  timed_out;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_off;

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Round num/den to nearest, ties away from zero
	function automatic longint div_nearest(input longint num, input longint den);
		longint mag;
		longint q;
		begin
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			div_nearest = (num < 0) ? -q : q;
		end
	endfunction

	function automatic logic signed [FieldW-1:0] clamp_field(input longint v);
		begin
			if (v > 64'sd2147483647)
				clamp_field = 32'sh7fffffff;
			else if (v < -64'sd2147483648)
				clamp_field = 32'sh80000000;
			else
				clamp_field = v[31:0];
		end
	endfunction

	// Apply one soft-iron row to the offset-corrected vector
	function automatic logic signed [FieldW-1:0] apply_row(input logic [RowW-1:0] row,
			input longint mx, input longint my, input longint mz);
		longint s;
		logic signed [CoefW-1:0] c0, c1, c2;
		begin
			c0 = row[15:0];
			c1 = row[31:16];
			c2 = row[47:32];
			s = longint'(c0) * mx + longint'(c1) * my + longint'(c2) * mz;
			apply_row = clamp_field(div_nearest(s, 64'd8192));
		end
	endfunction

	function automatic field_t calibrate(input request_t r);
		longint n;
		longint m [3];
		longint raw [3];
		field_t f;
		begin
			n = longint'(r.count);
			if (n < 1)
				n = 1;
			if (n > MaxSumCount)
				n = MaxSumCount;
			raw[0] = longint'(r.raw_x);
			raw[1] = longint'(r.raw_y);
			raw[2] = longint'(r.raw_z);
			for (int a = 0; a < 3; a++)
				m[a] = div_nearest(raw[a] * longint'(cal_sens), n * 256) -
					longint'(cal_hard[a]);
			f.fx = apply_row(cal_row[0], m[0], m[1], m[2]);
			f.fy = apply_row(cal_row[1], m[0], m[1], m[2]);
			f.fz = apply_row(cal_row[2], m[0], m[1], m[2]);
			f.sample = r.sample;
			calibrate = f;
		end
	endfunction

	// Register write over the config port, mirrored into the calibration copy
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= CfgAddrW'(8 * int'(idx));
			pwdata <= value;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			case (idx)
				REG_SENS:   cal_sens <= value[SensW-1:0];
				REG_HARD_X: cal_hard[0] <= value[31:0];
				REG_HARD_Y: cal_hard[1] <= value[31:0];
				REG_HARD_Z: cal_hard[2] <= value[31:0];
				REG_ROW_X:  cal_row[0] <= value[RowW-1:0];
				REG_ROW_Y:  cal_row[1] <= value[RowW-1:0];
				REG_ROW_Z:  cal_row[2] <= value[RowW-1:0];
				default: ;
			endcase
			@(posedge clk);
		end
	endtask

	// Offer one request, idling at random, and queue its field when taken
	task automatic send_request(input request_t r, input bit known, input field_t kf);
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= {r.sample, r.count, r.raw_z, r.raw_y, r.raw_x};
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			field_q.push_back(calibrate(r));
			known_q.push_back(known);
			known_fld_q.push_back(kf);
		end
	endtask

	// Drop the request line and wait for the pipeline to empty
	task automatic drain;
		begin
			s_tvalid <= 1'b0;
			while (field_q.size() != 0 && !timed_out)
				@(posedge clk);
			repeat (Lat + 4) @(posedge clk);
		end
	endtask

	function automatic request_t random_request();
		request_t r;
		begin
			r.raw_x = RawW'($urandom);
			r.raw_y = RawW'($urandom);
			r.raw_z = RawW'($urandom);
			case ($urandom_range(3))
				0: r.count = CountW'($urandom_range(1, 0));
				1: r.count = CountW'($urandom_range(255, 250));
				default: r.count = CountW'($urandom);
			endcase
			if ($urandom_range(3) == 0) begin
				r.raw_x = $urandom_range(1) ? 20'sh7ffff : 20'sh80000;
				r.raw_z = $urandom_range(1) ? 20'sh7ffff : 20'sh80000;
			end
			r.sample = SampW'($urandom);
			random_request = r;
		end
	endfunction

	function automatic logic [RowW-1:0] random_row();
		logic [RowW-1:0] row;
		begin
			row = RowW'({$urandom, $urandom});
			if ($urandom_range(2) == 0)
				row = {3{$urandom_range(1) ? 16'h7fff : 16'h8000}};
			random_row = row;
		end
	endfunction

	// Receiver: random stalls, plus the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each result against the oldest expected field
	always @(posedge clk) begin
		field_t got;
		field_t exp;
		bit     known;
		field_t kf;
		if (arst_n && m_tvalid && m_tready) begin
			got.fx = m_tdata[31:0];
			got.fy = m_tdata[63:32];
			got.fz = m_tdata[95:64];
			got.sample = m_tdata[111:96];
			if (field_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", m_tdata);
			end else begin
				exp = field_q.pop_front();
				known = known_q.pop_front();
				kf = known_fld_q.pop_front();
				if (known)
					exp = kf;
				if (got.fx !== exp.fx || got.fy !== exp.fy || got.fz !== exp.fz ||
						got.sample !== exp.sample) begin
					mismatches++;
					if (mismatches <= 10)
						$display("field mismatch: exp x=%0d y=%0d z=%0d n=%0d got x=%0d y=%0d z=%0d n=%0d",
							exp.fx, exp.fy, exp.fz, exp.sample,
							got.fx, got.fy, got.fz, got.sample);
				end
			end
		end
	end

	// Watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Directed table, reset calibration first, then full scale
	vector_t table_rows [$];

	function automatic vector_t row_of(input int x, input int y, input int z,
			input int c, input int s, input bit known,
			input int ex, input int ey, input int ez);
		vector_t v;
		begin
			v.req.raw_x = RawW'(x);
			v.req.raw_y = RawW'(y);
			v.req.raw_z = RawW'(z);
			v.req.count = CountW'(c);
			v.req.sample = SampW'(s);
			v.known = known;
			v.fld.fx = FieldW'(ex);
			v.fld.fy = FieldW'(ey);
			v.fld.fz = FieldW'(ez);
			v.fld.sample = SampW'(s);
			row_of = v;
		end
	endfunction

	initial begin
		request_t r;
		field_t   none;
		int       phase;
		none = '{default: '0};
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		hold_off = 1'b0;
		send_idle_pct = 30;
		recv_idle_pct = 72;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cal_sens = SensRst;
		cal_hard[0] = 0;
		cal_hard[1] = 0;
		cal_hard[2] = 0;
		cal_row[0] = RowXRst;
		cal_row[1] = RowYRst;
		cal_row[2] = RowZRst;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Under reset calibration: zero in gives zero out; other rows are checked by calibrate()
		table_rows.push_back(row_of(0, 0, 0, 0, 16'h0000, 1, 0, 0, 0));
		table_rows.push_back(row_of(0, 0, 0, 255, 16'hffff, 1, 0, 0, 0));
		table_rows.push_back(row_of(1, -1, 0, 1, 16'h5555, 0, 0, 0, 0));
		table_rows.push_back(row_of(524287, -524288, 7, 0, 16'haaaa, 0, 0, 0, 0));
		table_rows.push_back(row_of(-524288, 524287, -1, 2, 3, 0, 0, 0, 0));
		table_rows.push_back(row_of(1000, 2000, -3000, 254, 4, 0, 0, 0, 0));
		table_rows.push_back(row_of(12345, -12345, 100, 17, 5, 0, 0, 0, 0));
		foreach (table_rows[i])
			send_request(table_rows[i].req, table_rows[i].known, table_rows[i].fld);
		drain();

		// Full-scale calibration: extreme sensitivity, offsets and coefficients
		write_reg(REG_SENS, 64'hffffff);
		write_reg(REG_HARD_X, 64'h8000_0000);
		write_reg(REG_HARD_Y, 64'h7fff_ffff);
		write_reg(REG_HARD_Z, 64'h0);
		write_reg(REG_ROW_X, 64'h7fff_7fff_7fff);
		write_reg(REG_ROW_Y, 64'h8000_8000_8000);
		write_reg(REG_ROW_Z, 64'h0000_0000_0000);
		table_rows.delete();
		table_rows.push_back(row_of(0, 0, 0, 0, 10, 0, 0, 0, 0));
		table_rows.push_back(row_of(524287, 524287, 524287, 1, 11, 0, 0, 0, 0));
		table_rows.push_back(row_of(-524288, -524288, -524288, 255, 12, 0, 0, 0, 0));
		table_rows.push_back(row_of(524287, -524288, 524287, 128, 13, 0, 0, 0, 0));
		// Zero sums leave only the offsets, which nearly cancel across each row
		table_rows.push_back(row_of(0, 0, 0, 0, 14, 1, 4, -4, 0));
		foreach (table_rows[i])
			send_request(table_rows[i].req, table_rows[i].known, table_rows[i].fld);
		drain();

		// Random phases with differing idling and random calibration
		for (phase = 0; phase < 6; phase++) begin
			case (phase % 3)
				0: begin send_idle_pct = 30; recv_idle_pct = 72; end
				1: begin send_idle_pct = 72; recv_idle_pct = 30; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			write_reg(REG_SENS, ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom) & 64'hffffff);
			write_reg(REG_HARD_X, 64'($urandom));
			write_reg(REG_HARD_Y, 64'($urandom_range(65535)));
			write_reg(REG_HARD_Z, 64'($urandom));
			write_reg(REG_ROW_X, 64'(random_row()));
			write_reg(REG_ROW_Y, 64'(random_row()));
			write_reg(REG_ROW_Z, 64'(random_row()));
			if (phase == 2) begin
				// Long receiver hold-off so the pipeline fills and stalls input
				fork
					begin
						hold_off = 1'b1;
						repeat (200) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			for (int k = 0; k < 320; k++) begin
				r = random_request();
				send_request(r, 1'b0, none);
			end
			drain();
		end

		if (mismatches == 0 && field_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mic_pkg.sv
hdl/mic_axis.sv
hdl/magnetometer_iron_calibration_core.sv
sim/testbench.sv
